@@ sv/scem_pkg.sv @@
// Shared types and constants for the cumulative seam energy map.
package scem_pkg;

  localparam int ROW_WIDTH_BITS = 11;
  localparam int ENERGY_BITS    = 8;
  localparam int SUM_BITS       = 20;

  localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = 11'd1024;

  // Input word: one pixel energy and the frame marker.
  typedef struct packed {
    logic [ENERGY_BITS-1:0] pixel_energy;
    logic                   frame_start;
  } in_word_t;

  // Result word: saturating cumulative energy and the row marker.
  typedef struct packed {
    logic [SUM_BITS-1:0] cumulative_energy;
    logic                row_end;
  } out_word_t;

  // Per-pixel control flags carried alongside the energy in the compute stage.
  typedef struct packed {
    logic first_row;
    logic has_left;
    logic has_right;
    logic fwd_below;
    logic fwd_right;
    logic row_end;
  } stage_ctl_t;

endpackage

@@ sv/scem_line_store.sv @@
// Line store: previous row's cumulative values, one write and two registered reads.
module scem_line_store #(
  parameter int DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr_b,
  output logic [scem_pkg::SUM_BITS-1:0] rd_data_a,
  output logic [scem_pkg::SUM_BITS-1:0] rd_data_b,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic [scem_pkg::SUM_BITS-1:0] wr_data
);
  import scem_pkg::*;

  logic [SUM_BITS-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Two read ports; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

@@ sv/scem_min_add.sv @@
// Compute stage: three-way minimum of the row below plus the pixel energy, saturating.
module scem_min_add (
  input  logic [scem_pkg::ENERGY_BITS-1:0] energy,
  input  scem_pkg::stage_ctl_t             ctl,
  input  logic [scem_pkg::SUM_BITS-1:0]    rd_below,
  input  logic [scem_pkg::SUM_BITS-1:0]    rd_right,
  input  logic [scem_pkg::SUM_BITS-1:0]    last_result,
  input  logic [scem_pkg::SUM_BITS-1:0]    left_value,
  output logic [scem_pkg::SUM_BITS-1:0]    below,
  output logic [scem_pkg::SUM_BITS-1:0]    result
);
  import scem_pkg::*;

  logic [SUM_BITS-1:0] right;
  logic [SUM_BITS-1:0] best;
  logic [SUM_BITS:0]   sum;

  // The previous word's result may not have reached the store yet.
  assign below = ctl.fwd_below ? last_result : rd_below;
  assign right = ctl.fwd_right ? last_result : rd_right;

  // Least of the neighbors that lie inside the row.
  always_comb begin
    best = below;
    if (ctl.has_left && (left_value < best)) begin
      best = left_value;
    end
    if (ctl.has_right && (right < best)) begin
      best = right;
    end
  end

  assign sum = {1'b0, best} + (SUM_BITS + 1)'(energy);

  // The bottom row passes energy through; later rows saturate at full scale.
  always_comb begin
    if (ctl.first_row) begin
      result = SUM_BITS'(energy);
    end else if (sum[SUM_BITS]) begin
      result = '1;
    end else begin
      result = sum[SUM_BITS-1:0];
    end
  end

endmodule

@@ sv/seam_cumulative_energy_map.sv @@
// An accepted word is held in the stage register, and its result in the output register.
// One word per cycle unless stalled, set by one two-port line-store read per pixel.
// A stalled result holds; a new input word is still taken while the compute stage is free.
// Synchronous active-low reset clears the handshake and column count, sets the first-row
// flag and sets the row width to 1024; the line store is not cleared.
module seam_cumulative_energy_map #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  scem_pkg::in_word_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output scem_pkg::out_word_t                    out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [scem_pkg::ROW_WIDTH_BITS-1:0]    cfg_wdata
);
  import scem_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WW > ROW_WIDTH_BITS) ? WW : ROW_WIDTH_BITS;

  // Control state.
  logic [ROW_WIDTH_BITS-1:0] row_width_r;
  logic [AW-1:0]             column_count_r, column_count_nxt;
  logic                      in_first_row_r, in_first_row_nxt;
  logic                      s1_valid_r, s1_valid_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // Stage payload.
  logic [ENERGY_BITS-1:0] s1_energy_r;
  logic [AW-1:0]          s1_col_r;
  stage_ctl_t             s1_ctl_r, s1_ctl_nxt;
  logic [SUM_BITS-1:0]    last_result_r;
  logic [SUM_BITS-1:0]    left_r;
  out_word_t              out_data_r;

  logic          out_free, s1_fire, in_acc;
  logic [CW-1:0] rw_ext, eff_w, cnt_ext, col_ext, col_plus1;
  logic          first_sel;
  logic [AW-1:0] col;
  logic          last_col;

  logic [SUM_BITS-1:0] rd_below, rd_right, below, result;

  // Handshake: the stage advances whenever the output register can take a word.
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Row width in use: zero acts as one, and it is capped at the store depth.
  assign rw_ext = CW'(row_width_r);
  always_comb begin
    if (rw_ext == '0) begin
      eff_w = CW'(1);
    end else if (rw_ext > CW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = rw_ext;
    end
  end

  function automatic logic [CW-1:0] frame_start_cnt();
    return in_data.frame_start ? '0 : CW'(column_count_r);
  endfunction

  // Column of the incoming word; a frame marker restarts the bottom row.
  always_comb begin
    cnt_ext   = frame_start_cnt();
    first_sel = in_data.frame_start ? 1'b1 : in_first_row_r;
    col_ext   = cnt_ext;
    if (cnt_ext >= eff_w) begin
      col_ext   = '0;
      first_sel = 1'b0;
    end
  end

  assign col       = col_ext[AW-1:0];
  assign col_plus1 = col_ext + CW'(1);
  assign last_col  = (col_plus1 == eff_w);

  // Counter update and the flags the compute stage needs.
  always_comb begin
    column_count_nxt = last_col ? '0 : col_plus1[AW-1:0];
    in_first_row_nxt = last_col ? 1'b0 : first_sel;
    s1_ctl_nxt.first_row = first_sel;
    s1_ctl_nxt.has_left  = (col_ext != '0);
    s1_ctl_nxt.has_right = (col_plus1 < eff_w);
    s1_ctl_nxt.fwd_below = s1_valid_r && (col == s1_col_r);
    s1_ctl_nxt.fwd_right = s1_valid_r && (col_plus1[AW-1:0] == s1_col_r);
    s1_ctl_nxt.row_end   = last_col;
  end

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_fire ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r    <= ROW_WIDTH_RESET;
      column_count_r <= '0;
      in_first_row_r <= 1'b1;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        row_width_r <= cfg_wdata;
      end
      if (in_acc) begin
        column_count_r <= column_count_nxt;
        in_first_row_r <= in_first_row_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_energy_r <= in_data.pixel_energy;
      s1_col_r    <= col;
      s1_ctl_r    <= s1_ctl_nxt;
    end
    if (s1_fire) begin
      last_result_r                <= result;
      left_r                       <= below;
      out_data_r.cumulative_energy <= result;
      out_data_r.row_end           <= s1_ctl_r.row_end;
    end
  end

  // Previous row's values at this column and the next.
  scem_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_store (
    .clk       (clk),
    .rd_en     (in_acc),
    .rd_addr_a (col),
    .rd_addr_b (col_plus1[AW-1:0]),
    .rd_data_a (rd_below),
    .rd_data_b (rd_right),
    .wr_en     (s1_fire),
    .wr_addr   (s1_col_r),
    .wr_data   (result)
  );

  scem_min_add u_min_add (
    .energy      (s1_energy_r),
    .ctl         (s1_ctl_r),
    .rd_below    (rd_below),
    .rd_right    (rd_right),
    .last_result (last_result_r),
    .left_value  (left_r),
    .below       (below),
    .result      (result)
  );

endmodule

@@ sv/scem_checker.sv @@
// Port-level checker for the cumulative seam energy map, bound to the top level.
module scem_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input scem_pkg::out_word_t out_data
);
  import scem_pkg::*;

  // A stalled result word stays and does not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed or dropped");

  // Reset leaves no result word pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The input side stalls only behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // A result word that appears on an idle output came from an accepted input word.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without a matching input word");

endmodule

bind seam_cumulative_energy_map scem_checker u_scem_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ sim/tb_top.sv @@
// Self-checking testbench for the cumulative seam energy map with a built-in path-sum predictor.
module tb_top;
  import scem_pkg::*;

  localparam int          MAX_W       = 1024;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          RANDOM_PIX  = 300;

  // Receiver stall modes.
  localparam int STALL_NONE     = 0;
  localparam int STALL_RANDOM   = 1;
  localparam int STALL_PERIODIC = 2;
  localparam int STALL_BURST    = 3;

  // Tracks the path-sum state of the block and holds the result words still owed.
  class seam_sum_scoreboard;
    logic [ROW_WIDTH_BITS-1:0] row_width;
    logic [SUM_BITS-1:0]       line_sum [MAX_W];
    bit                        seen [MAX_W];
    int unsigned               column;
    logic [SUM_BITS-1:0]       left_saved;
    bit                        first_row;
    out_word_t                 awaited_words [$];
    int                        errors;
    int                        word_index;

    function new();
      row_width  = ROW_WIDTH_RESET;
      column     = 0;
      left_saved = '0;
      first_row  = 1'b1;
      errors     = 0;
      word_index = 0;
      foreach (line_sum[i]) begin
        line_sum[i] = '0;
        seen[i]     = 1'b0;
      end
    endfunction

    function void set_width(logic [ROW_WIDTH_BITS-1:0] value);
      row_width = value;
    endfunction

    // A zero width acts as one, and widths beyond the store clamp to its size.
    function int unsigned eff_width();
      if (row_width == 0) return 1;
      if (row_width > MAX_W) return MAX_W;
      return row_width;
    endfunction

    // True when a word without frame start would read a line-store entry never written.
    function bit blank_read(logic fs);
      int unsigned w;
      int unsigned col;
      if (fs) return 1'b0;
      w   = eff_width();
      col = (column >= w) ? 0 : column;
      if (first_row && column < w) return 1'b0;
      return !seen[col] || (col + 1 < w && !seen[col + 1]);
    endfunction

    // Works out the result word for an accepted pixel and queues it.
    function void take_pixel(in_word_t px);
      int unsigned         w;
      int unsigned         col;
      logic [SUM_BITS-1:0] below;
      logic [SUM_BITS-1:0] best;
      logic [SUM_BITS-1:0] sum_now;
      logic [SUM_BITS:0]   total;
      out_word_t           want;
      w = eff_width();
      if (px.frame_start) begin
        column     = 0;
        left_saved = '0;
        first_row  = 1'b1;
      end
      col = column;
      // A column past the current width starts a new row that is not the first.
      if (col >= w) begin
        col       = 0;
        first_row = 1'b0;
      end
      below = line_sum[col];
      if (first_row) begin
        sum_now = SUM_BITS'(px.pixel_energy);
      end else begin
        best = below;
        if (col > 0 && left_saved < best) best = left_saved;
        if (col + 1 < w && line_sum[col + 1] < best) best = line_sum[col + 1];
        total   = {1'b0, best} + (SUM_BITS + 1)'(px.pixel_energy);
        sum_now = total[SUM_BITS] ? '1 : total[SUM_BITS-1:0];
      end
      left_saved    = below;
      line_sum[col] = sum_now;
      seen[col]     = 1'b1;
      want.cumulative_energy = sum_now;
      want.row_end           = (col + 1 == w);
      if (col + 1 == w) begin
        column    = 0;
        first_row = 1'b0;
      end else begin
        column = col + 1;
      end
      awaited_words.push_back(want);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("mismatch at result word %0d: %s", word_index, msg);
    endfunction

    // Compares an accepted result word with the oldest one owed.
    function void check_result(out_word_t got);
      out_word_t want;
      if (awaited_words.size() == 0) begin
        note_error($sformatf("unexpected word, energy %0d row_end %0b",
                             got.cumulative_energy, got.row_end));
      end else begin
        want = awaited_words.pop_front();
        if (got.cumulative_energy !== want.cumulative_energy)
          note_error($sformatf("cumulative_energy expected %0d got %0d",
                               want.cumulative_energy, got.cumulative_energy));
        if (got.row_end !== want.row_end)
          note_error($sformatf("row_end expected %0b got %0b", want.row_end, got.row_end));
      end
      word_index++;
    endfunction
  endclass

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  in_word_t                  in_data   = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  out_word_t                 out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [ROW_WIDTH_BITS-1:0] cfg_wdata = '0;

  seam_sum_scoreboard sb = new();

  int          burst_left  = 0;
  int          pixels_sent = 0;
  int unsigned cycle_count = 0;
  int          stall_mode  = STALL_NONE;
  int          mode_left   = 0;
  int          hold_left   = 0;
  logic        hold_val    = 1'b0;

  seam_cumulative_energy_map #(.MAX_WIDTH(MAX_W)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** seam_cumulative_energy_map: FAILED **");
      $finish;
    end
  end

  // Result side stalls in modes that change every so often.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_BURST);
      mode_left  = $urandom_range(16, 200);
    end
    mode_left = mode_left - 1;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
      STALL_PERIODIC: out_stall <= (mode_left % 4 == 0);
      default: begin
        if (hold_left == 0) begin
          hold_val  = ~hold_val;
          hold_left = $urandom_range(1, 10);
        end
        hold_left = hold_left - 1;
        out_stall <= hold_val;
      end
    endcase
  end

  // Every accepted result word goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic logic [ENERGY_BITS-1:0] rand_energy();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return ENERGY_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends one pixel word in bursts with gaps; a frame start is forced where the
  // word would otherwise read line-store entries that hold nothing yet.
  task automatic send_pixel(input logic [ENERGY_BITS-1:0] energy, input logic fs);
    in_word_t word_in;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 16);
    end
    word_in.pixel_energy = energy;
    word_in.frame_start  = fs | sb.blank_read(fs);
    in_valid <= 1'b1;
    in_data  <= word_in;
    do @(posedge clk); while (in_stall);
    sb.take_pixel(word_in);
    burst_left--;
    pixels_sent++;
  endtask

  // Waits until every owed result word has been taken.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.awaited_words.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_width(input logic [ROW_WIDTH_BITS-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_width(value);
  endtask

  function automatic logic [ROW_WIDTH_BITS-1:0] pick_width();
    case ($urandom_range(0, 9))
      0:       return ROW_WIDTH_BITS'(0);
      1:       return ROW_WIDTH_BITS'(1);
      2:       return ROW_WIDTH_BITS'(2);
      3, 4, 5: return ROW_WIDTH_BITS'($urandom_range(3, 8));
      6, 7:    return ROW_WIDTH_BITS'($urandom_range(9, 40));
      8:       return ROW_WIDTH_BITS'($urandom_range(41, 200));
      default: return ROW_WIDTH_BITS'($urandom_range(3, 16));
    endcase
  endfunction

  // Whole frames of a few rows each, now and then cut short or hit by a stray frame start.
  task automatic run_frames(input int target);
    int done_n;
    int len;
    int p;
    done_n = 0;
    while (done_n < target) begin
      len = sb.eff_width() * $urandom_range(2, 6);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len);
      for (p = 0; p < len && done_n < target; p++) begin
        send_pixel(rand_energy(), (p == 0) || ($urandom_range(0, 79) == 0));
        done_n++;
      end
    end
  endtask

  initial begin
    int rand_start;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First row at the reset width passes energies through.
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'h5A, 1'b0);

    // Three-wide frame: edge columns see only two neighbors.
    write_width(11'd3);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd170, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);

    // A zero width behaves as a single column.
    write_width(11'd0);
    send_pixel(8'd7, 1'b0);
    send_pixel(8'd255, 1'b0);

    // Width shrunk in the middle of a first row.
    write_width(11'd8);
    send_pixel(8'd200, 1'b1);
    repeat (5) send_pixel(rand_energy(), 1'b0);
    write_width(11'd3);
    repeat (3) send_pixel(rand_energy(), 1'b0);

    // Width above the store size clamps.
    write_width(11'd2047);
    send_pixel(8'd9, 1'b1);
    send_pixel(8'd200, 1'b0);

    // Random phases, mostly narrow rows.
    rand_start = pixels_sent;
    while (pixels_sent - rand_start < RANDOM_PIX) begin
      write_width(pick_width());
      run_frames($urandom_range(60, 200));
    end

    // One full-width row and part of the next.
    write_width(ROW_WIDTH_BITS'($urandom_range(1024, 2047)));
    send_pixel(rand_energy(), 1'b1);
    repeat (MAX_W - 1 + $urandom_range(20, 60)) send_pixel(rand_energy(), 1'b0);

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** seam_cumulative_energy_map: PASSED **");
    end else begin
      $display("** seam_cumulative_energy_map: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/scem_pkg.sv
sv/scem_line_store.sv
sv/scem_min_add.sv
sv/seam_cumulative_energy_map.sv
sv/scem_checker.sv
sim/tb_top.sv
